FILE: hdl/additive_oscillator_voice_adsr_macros.svh
// Assertion macros shared by the voice RTL.
`ifndef ADDITIVE_OSCILLATOR_VOICE_ADSR_MACROS_SVH
`define ADDITIVE_OSCILLATOR_VOICE_ADSR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AOV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AOV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/aov_pkg.sv
// Shared constants and types of the additive voice.
package aov_pkg;

	localparam int MAX_OSCS_DEF   = 4;
	localparam int SINE_DEPTH_DEF = 256;
	localparam int SLOTS          = 4;

	localparam int NUM_W = 52;
	localparam int DEN_W = 32;

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	localparam logic [15:0] ENV_ONE       = 16'd4096;
	localparam logic [15:0] PEAK_RESET    = 16'd4096;

	localparam logic [2:0] KIND_SINE     = 3'd0;
	localparam logic [2:0] KIND_TRIANGLE = 3'd1;
	localparam logic [2:0] KIND_SQUARE   = 3'd2;
	localparam logic [2:0] KIND_SAW      = 3'd3;
	localparam logic [2:0] KIND_NOISE    = 3'd4;

	localparam logic [2:0] REG_OSC_KINDS   = 3'd0;
	localparam logic [2:0] REG_OSC_WEIGHTS = 3'd1;
	localparam logic [2:0] REG_OSC_COUNT   = 3'd2;
	localparam logic [2:0] REG_ATTACK_LEN  = 3'd3;
	localparam logic [2:0] REG_ATTACK_PEAK = 3'd4;
	localparam logic [2:0] REG_DECAY_LEN   = 3'd5;
	localparam logic [2:0] REG_RELEASE_LEN = 3'd6;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: hdl/aov_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module aov_div (
	input  logic               clk,
	input  logic               arst_n,
	input  aov_pkg::div_req_t  req,
	output aov_pkg::div_rsp_t  rsp
);
	localparam int NW = aov_pkg::NUM_W;
	localparam int DW = aov_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

FILE: hdl/additive_oscillator_voice_adsr.sv
// Voice of up to four additive oscillators with an attack/decay/sustain/release envelope.
// One item is taken while the voice is idle and gives one sample. Each slot in use goes
// through a shared multiply-accumulate, and two passes through the single bit-serial
// divider (the envelope segment and the weight normalisation) take the bulk of the work; a
// sustain, zero-level or zero-weight case skips one or both passes. The result sits in an
// output register, so the next item is taken while a sample still waits to be collected.
module additive_oscillator_voice_adsr #(
	parameter int MAX_OSCS         = aov_pkg::MAX_OSCS_DEF,
	parameter int SINE_TABLE_DEPTH = aov_pkg::SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        time_now,
	input  logic [23:0]        frequency,
	input  logic [31:0]        note_length,
	input  logic [15:0]        phase_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample
);
	`include "additive_oscillator_voice_adsr_macros.svh"

	localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SLOT_W  = $clog2(aov_pkg::SLOTS);
	localparam int LIMIT   = (MAX_OSCS < aov_pkg::SLOTS) ? MAX_OSCS : aov_pkg::SLOTS;
	localparam int ACC_W   = 37;
	localparam int NW      = aov_pkg::NUM_W;
	localparam int DW      = aov_pkg::DEN_W;

	typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

	// Quarter-wave Taylor series in Q30, folded into the four quadrants.
	function automatic sine_rom_t build_sine();
		sine_rom_t        tab;
		longint unsigned  n, quad, r, x, x2, acc, s, v;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			n    = 4 * k;
			quad = n / SINE_TABLE_DEPTH;
			r    = n - quad * SINE_TABLE_DEPTH;
			if (quad[0])
				r = SINE_TABLE_DEPTH - r;
			x    = (aov_pkg::HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			acc  = aov_pkg::ONE_Q30;
			acc  = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / 110;
			acc  = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / 72;
			acc  = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / 42;
			acc  = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / 20;
			acc  = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / 6;
			s    = (x * acc) >> 30;
			v    = (s + 32768) >> 16;
			tab[k] = (quad >= 2) ? -16'(v) : 16'(v);
		end
		return tab;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	typedef enum logic [3:0] {
		S_IDLE, S_IDX, S_ROM, S_SLOT, S_SEG, S_EMUL, S_EDIV, S_MIX, S_MDIV, S_OUT
	} state_t;

	typedef enum logic [2:0] {SEG_ATT, SEG_DEC, SEG_SUS, SEG_REL, SEG_ZERO} seg_t;

	// Configuration registers.
	logic [11:0] osc_kinds_q;
	logic [63:0] osc_weights_q;
	logic [2:0]  osc_count_q;
	logic [31:0] attack_len_q;
	logic [15:0] attack_peak_q;
	logic [31:0] decay_len_q;
	logic [31:0] release_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_kinds_q   <= '0;
			osc_weights_q <= '0;
			osc_count_q   <= '0;
			attack_len_q  <= '0;
			attack_peak_q <= aov_pkg::PEAK_RESET;
			decay_len_q   <= '0;
			release_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				aov_pkg::REG_OSC_KINDS:   osc_kinds_q   <= cfg_data[11:0];
				aov_pkg::REG_OSC_WEIGHTS: osc_weights_q <= cfg_data;
				aov_pkg::REG_OSC_COUNT:   osc_count_q   <= cfg_data[2:0];
				aov_pkg::REG_ATTACK_LEN:  attack_len_q  <= cfg_data[31:0];
				aov_pkg::REG_ATTACK_PEAK: attack_peak_q <= cfg_data[15:0];
				aov_pkg::REG_DECAY_LEN:   decay_len_q   <= cfg_data[31:0];
				aov_pkg::REG_RELEASE_LEN: release_len_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	state_t                  state_q;
	seg_t                    seg_q;
	logic [31:0]             t_q;
	logic [31:0]             hold_q;
	logic [23:0]             p_q;
	logic [2:0]              n_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [15:0]      rom_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [17:0]             wsum_q;
	logic [32:0]             diff_q;
	logic [15:0]             env_q;
	logic                    neg_q;
	logic [31:0]             lfsr_q;
	logic signed [15:0]      res_q;
	logic signed [15:0]      sample_q;
	logic                    out_valid_q;
	aov_pkg::div_req_t       div_req_q;
	aov_pkg::div_rsp_t       div_rsp;

	aov_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		rom_q <= SINE_ROM[idx_q];
	end

	// Per-slot waveform and product.
	logic [2:0]              kind;
	logic [15:0]             weight;
	logic [31:0]             lfsr_next;
	logic signed [17:0]      wv;
	logic signed [34:0]      wprod;
	logic [23:0]             ph_mul;
	logic [24+DEPTH_W-1:0]   idx_mul;
	logic [3:0]              n_clamp;

	assign kind      = osc_kinds_q[3*slot_q +: 3];
	assign weight    = osc_weights_q[16*slot_q +: 16];
	assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? aov_pkg::LFSR_MASK : 32'd0);
	assign ph_mul    = 24'(time_now[23:0] * frequency) + {phase_offset, 8'd0};
	assign idx_mul   = (24+DEPTH_W)'(p_q) * (24+DEPTH_W)'(SINE_TABLE_DEPTH);
	assign n_clamp   = ({1'b0, osc_count_q} > 4'(LIMIT)) ? 4'(LIMIT) : {1'b0, osc_count_q};
	assign wprod     = $signed({1'b0, weight}) * wv;

	always_comb begin
		case (kind)
			aov_pkg::KIND_SINE:     wv = 18'(rom_q);
			aov_pkg::KIND_TRIANGLE: begin
				if (p_q < 24'h40_0000)
					wv = $signed({2'b0, p_q[23:8]});
				else if (p_q < 24'hC0_0000)
					wv = 18'sd32768 - $signed({2'b0, p_q[23:8]});
				else
					wv = $signed({2'b0, p_q[23:8]}) - 18'sd65536;
			end
			aov_pkg::KIND_SQUARE:   wv = p_q[23] ? -18'sd16384 : 18'sd16384;
			aov_pkg::KIND_SAW:      wv = $signed({3'b0, p_q[23:9]}) - (p_q[23] ? 18'sd32768 : 18'sd0);
			aov_pkg::KIND_NOISE:    wv = $signed({3'b0, lfsr_next[31:17]}) - 18'sd16384;
			default:                wv = '0;
		endcase
	end

	// Envelope segment boundaries.
	logic [33:0] end_ad, end_adh, rel_e;
	logic [15:0] dec_mag;
	logic [ACC_W-1:0] acc_abs;
	logic [NW-1:0] q_lo;

	assign end_ad  = 34'(attack_len_q) + 34'(decay_len_q);
	assign end_adh = end_ad + 34'(hold_q);
	assign rel_e   = 34'(t_q) - end_adh;
	assign dec_mag = (attack_peak_q < aov_pkg::ENV_ONE) ? (aov_pkg::ENV_ONE - attack_peak_q)
	                                                    : (attack_peak_q - aov_pkg::ENV_ONE);
	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign q_lo    = div_rsp.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			out_valid_q     <= 1'b0;
			lfsr_q          <= aov_pkg::LFSR_SEED;
			div_req_q.start <= 1'b0;
		end else begin
			div_req_q.start <= ((state_q == S_EMUL) && (seg_q inside {SEG_ATT, SEG_DEC, SEG_REL}))
			                   || ((state_q == S_MIX) && (wsum_q != '0));
			if ((state_q == S_OUT) && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						t_q     <= time_now;
						hold_q  <= note_length;
						p_q     <= ph_mul;
						n_q     <= n_clamp[2:0];
						slot_q  <= '0;
						acc_q   <= '0;
						wsum_q  <= '0;
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					idx_q   <= idx_mul[24 +: IDX_W];
					state_q <= S_ROM;
				end
				S_ROM: state_q <= (n_q != 3'd0) ? S_SLOT : S_SEG;
				S_SLOT: begin
					acc_q  <= acc_q + ACC_W'(wprod);
					wsum_q <= wsum_q + 18'(weight);
					if (kind == aov_pkg::KIND_NOISE)
						lfsr_q <= lfsr_next;
					slot_q <= slot_q + 1'b1;
					if (3'(slot_q) + 3'd1 == n_q)
						state_q <= S_SEG;
				end
				S_SEG: begin
					if (t_q < attack_len_q) begin
						seg_q <= SEG_ATT;
					end else if (34'(t_q) < end_ad) begin
						seg_q  <= SEG_DEC;
						diff_q <= 33'(t_q - attack_len_q);
					end else if (34'(t_q) < end_adh) begin
						seg_q <= SEG_SUS;
					end else if (rel_e >= 34'(release_len_q)) begin
						seg_q <= SEG_ZERO;
					end else begin
						seg_q  <= SEG_REL;
						diff_q <= rel_e[32:0];
					end
					state_q <= S_EMUL;
				end
				S_EMUL: begin
					case (seg_q)
						SEG_ATT: begin
							div_req_q.num <= NW'(t_q) * NW'(attack_peak_q);
							div_req_q.den <= attack_len_q;
							state_q       <= S_EDIV;
						end
						SEG_DEC: begin
							div_req_q.num <= NW'(diff_q) * NW'(dec_mag);
							div_req_q.den <= decay_len_q;
							state_q       <= S_EDIV;
						end
						SEG_REL: begin
							div_req_q.num <= NW'({diff_q, 12'd0});
							div_req_q.den <= release_len_q;
							state_q       <= S_EDIV;
						end
						SEG_SUS: begin
							env_q   <= aov_pkg::ENV_ONE;
							state_q <= S_MIX;
						end
						default: begin
							env_q   <= '0;
							state_q <= S_MIX;
						end
					endcase
				end
				S_EDIV: begin
					if (div_rsp.done) begin
						case (seg_q)
							SEG_ATT: env_q <= q_lo[15:0];
							SEG_DEC: env_q <= (attack_peak_q < aov_pkg::ENV_ONE)
							                  ? attack_peak_q + q_lo[15:0]
							                  : attack_peak_q - q_lo[15:0];
							default: env_q <= aov_pkg::ENV_ONE - q_lo[15:0];
						endcase
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (wsum_q == '0) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else begin
						neg_q         <= acc_q[ACC_W-1];
						div_req_q.num <= NW'(acc_abs) * NW'(env_q);
						div_req_q.den <= DW'({wsum_q, 12'd0});
						state_q       <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (div_rsp.done) begin
						// Quotient is a magnitude truncated toward zero; saturate by sign.
						if (neg_q)
							res_q <= (q_lo > NW'(32768)) ? -16'sd32768 : 16'(-q_lo);
						else
							res_q <= (q_lo > NW'(32767)) ? 16'sd32767 : 16'(q_lo);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						sample_q <= res_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	`AOV_ASSERT_NOW(a_div_idle_on_start, div_req_q.start, !div_rsp.busy, "divider started while busy")
	`AOV_ASSERT_NOW(a_slot_in_range, state_q == S_SLOT, 3'(slot_q) < n_q, "slot index past count")
	`AOV_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr_q != 32'd0, "noise register reached zero")
	`AOV_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_q == S_IDX, "item not started")
endmodule

FILE: bench/tb_additive_oscillator_voice_adsr.sv
// Self-checking testbench of the additive oscillator voice with its envelope.
module tb_additive_oscillator_voice_adsr;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int TAB_DEPTH = aov_pkg::SINE_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 140;

	// Predicts the samples of the voice and holds them until the block returns them.
	class voice_scoreboard;
		logic [11:0] kinds;
		logic [63:0] weights;
		logic [2:0] count;
		logic [31:0] atk_len, dec_len, rel_len;
		logic [15:0] peak;
		logic [31:0] lfsr;
		int signed sine_rom[TAB_DEPTH];
		logic signed [15:0] samples_due[$];
		int errors;

		function new();
			longint unsigned n, quad, r, x, x2, acc, s;
			longint unsigned dens[5];
			int signed v;
			dens = '{110, 72, 42, 20, 6};
			kinds = '0;
			weights = '0;
			count = '0;
			atk_len = '0;
			dec_len = '0;
			rel_len = '0;
			peak = aov_pkg::PEAK_RESET;
			lfsr = aov_pkg::LFSR_SEED;
			errors = 0;
			// Quarter-wave Taylor series in Q30, folded out to the full cycle.
			for (int k = 0; k < TAB_DEPTH; k++) begin
				n = 4 * k;
				quad = n / TAB_DEPTH;
				r = n - quad * TAB_DEPTH;
				if (quad[0])
					r = TAB_DEPTH - r;
				x = (aov_pkg::HALF_PI_Q30 * r) / TAB_DEPTH;
				x2 = (x * x) >> 30;
				acc = aov_pkg::ONE_Q30;
				for (int i = 0; i < 5; i++)
					acc = aov_pkg::ONE_Q30 - ((x2 * acc) >> 30) / dens[i];
				s = (x * acc) >> 30;
				v = int'((s + 32768) >> 16);
				sine_rom[k] = (quad >= 2) ? -v : v;
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] value);
			case (idx)
				aov_pkg::REG_OSC_KINDS:   kinds = value[11:0];
				aov_pkg::REG_OSC_WEIGHTS: weights = value;
				aov_pkg::REG_OSC_COUNT:   count = value[2:0];
				aov_pkg::REG_ATTACK_LEN:  atk_len = value[31:0];
				aov_pkg::REG_ATTACK_PEAK: peak = value[15:0];
				aov_pkg::REG_DECAY_LEN:   dec_len = value[31:0];
				aov_pkg::REG_RELEASE_LEN: rel_len = value[31:0];
				default: ;
			endcase
		endfunction

		function longint signed osc_value(logic [2:0] kind, logic [23:0] p);
			logic out_bit;
			case (kind)
				aov_pkg::KIND_SINE:
					return sine_rom[p[23:16]];
				aov_pkg::KIND_TRIANGLE:
					if (p < 24'h40_0000)
						return longint'(p >> 8);
					else if (p < 24'hC0_0000)
						return 32768 - longint'(p >> 8);
					else
						return longint'(p >> 8) - 65536;
				aov_pkg::KIND_SQUARE:
					return (p < 24'h80_0000) ? 16384 : -16384;
				aov_pkg::KIND_SAW:
					return (p < 24'h80_0000) ? longint'(p >> 9) : longint'(p >> 9) - 32768;
				aov_pkg::KIND_NOISE: begin
					out_bit = lfsr[0];
					lfsr = lfsr >> 1;
					if (out_bit)
						lfsr = lfsr ^ aov_pkg::LFSR_MASK;
					return longint'(lfsr[31:17]) - 16384;
				end
				default:
					return 0;
			endcase
		endfunction

		function longint signed env_level(longint unsigned t, longint unsigned hold);
			longint unsigned a, d, r, e;
			longint signed pk;
			a = atk_len;
			d = dec_len;
			r = rel_len;
			pk = longint'(peak);
			if (t < a)
				return longint'((t * peak) / a);
			if (t < a + d)
				return pk - ((pk - 4096) * longint'(t - a)) / longint'(d);
			if (t < a + d + hold)
				return 4096;
			e = t - a - d - hold;
			if (e >= r)
				return 0;
			return 4096 - longint'((4096 * e) / r);
		endfunction

		// An item has been taken by the block: work out the sample it must give.
		function void note_item(logic [31:0] t, logic [23:0] f, logic [31:0] hold,
				logic [15:0] ph);
			longint unsigned prod, wsum, w;
			logic [23:0] p;
			int nslots;
			longint signed acc, val;
			prod = longint'(t) * longint'(f) + (longint'(ph) << 8);
			p = prod[23:0];
			nslots = (count > aov_pkg::SLOTS) ? aov_pkg::SLOTS : count;
			wsum = 0;
			acc = 0;
			val = 0;
			for (int i = 0; i < nslots; i++) begin
				w = weights[16*i +: 16];
				acc += longint'(w) * osc_value(kinds[3*i +: 3], p);
				wsum += w;
			end
			if (wsum != 0) begin
				val = (acc * env_level(t, hold)) / longint'(wsum * 4096);
				if (val > 32767)
					val = 32767;
				if (val < -32768)
					val = -32768;
			end
			samples_due.push_back(val[15:0]);
		endfunction

		function void check_sample(logic signed [15:0] got);
			logic signed [15:0] want;
			if (samples_due.size() == 0) begin
				$display("%0t: unexpected sample, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = samples_due.pop_front();
			if (got !== want) begin
				$display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] time_now = '0;
	logic [23:0] frequency = '0;
	logic [31:0] note_length = '0;
	logic [15:0] phase_offset = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] sample;

	voice_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	logic [31:0] span;

	additive_oscillator_voice_adsr dut (.*);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(sample);

	// Receiver side: random stall bursts, and one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				out_stall = 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic send_item(logic [31:0] t, logic [23:0] f, logic [31:0] hold,
			logic [15:0] ph);
		@(negedge clk);
		time_now = t;
		frequency = f;
		note_length = hold;
		phase_offset = ph;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(t, f, hold, ph);
		if (!quiet && !hold_req && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	endtask

	// Lets every outstanding sample come back, then lets the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_voice(logic [11:0] k, logic [63:0] w, logic [2:0] n,
			logic [31:0] a, logic [15:0] pk, logic [31:0] d, logic [31:0] r);
		write_reg(aov_pkg::REG_OSC_KINDS, 64'(k));
		write_reg(aov_pkg::REG_OSC_WEIGHTS, w);
		write_reg(aov_pkg::REG_OSC_COUNT, 64'(n));
		write_reg(aov_pkg::REG_ATTACK_LEN, 64'(a));
		write_reg(aov_pkg::REG_ATTACK_PEAK, 64'(pk));
		write_reg(aov_pkg::REG_DECAY_LEN, 64'(d));
		write_reg(aov_pkg::REG_RELEASE_LEN, 64'(r));
	endtask

	task automatic random_voice();
		logic [63:0] w;
		w = {$urandom, $urandom};
		for (int i = 0; i < 4; i++)
			if ($urandom_range(0, 4) == 0)
				w[16*i +: 16] = '0;
		load_voice(12'($urandom_range(0, 4095)), w, 3'($urandom_range(0, 7)),
			$urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h4_0000),
			16'($urandom_range(0, 65535)),
			$urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h4_0000),
			$urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 32'h4_0000));
	endtask

	// Times are mostly spread over the envelope so that every segment is visited.
	task automatic random_items(int num);
		logic [31:0] t, hold;
		for (int i = 0; i < num; i++) begin
			hold = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h4_0000);
			span = sb.atk_len + sb.dec_len + sb.rel_len + 32'h1_0000;
			t = ($urandom_range(0, 4) == 0) ? $urandom :
				$urandom_range(0, (span > 32'h40_0000) ? 32'hFFFF_FFFF : span + hold);
			send_item(t, 24'($urandom_range(0, 24'hFF_FFFF)), hold,
				16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sine, triangle, square and sawtooth at equal weight, with all segments in use.
		load_voice({aov_pkg::KIND_SINE, aov_pkg::KIND_SAW, aov_pkg::KIND_SQUARE,
			aov_pkg::KIND_TRIANGLE},
			64'h0100_0100_0100_0100, 3'd4, 32'h1_0000, 16'h2000, 32'h8000, 32'h1_0000);
		write_reg(aov_pkg::REG_OSC_KINDS, 64'({aov_pkg::KIND_SAW, aov_pkg::KIND_SQUARE,
			aov_pkg::KIND_TRIANGLE, aov_pkg::KIND_SINE}));
		send_item(32'h0, 24'h0, 32'h0, 16'h0);
		send_item(32'h8000, 24'h100, 32'h1_0000, 16'h4000);
		send_item(32'h1_4000, 24'h100, 32'h1_0000, 16'h8000);
		send_item(32'h2_0000, 24'h380, 32'h1_0000, 16'hC000);
		send_item(32'h2_C000, 24'h1B8, 32'h1_0000, 16'h1234);
		send_item(32'h9_0000, 24'h1B8, 32'h1_0000, 16'h0);
		send_item(32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(32'hFFFF_FFFF, 24'hFF_FFFF, 32'h0, 16'hFFFF);
		drain();

		// Noise slots, unused kind codes and a register index that does not exist.
		load_voice({aov_pkg::KIND_NOISE, 3'd7, 3'd5, aov_pkg::KIND_NOISE},
			64'hFFFF_0001_8000_0100, 3'd7, 32'h0, 16'hFFFF, 32'h0, 32'h0);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(32'h0, 24'h1, 32'h1_0000, 16'h0);
		send_item(32'h8000, 24'h1, 32'h1_0000, 16'h0);
		send_item(32'h1_0000, 24'h1, 32'h1_0000, 16'h0);
		send_item(32'h3_0000, 24'h1, 32'h1_0000, 16'h0);
		drain();

		// Zero weight sum with noise still running, then no slot at all.
		load_voice({4{aov_pkg::KIND_NOISE}}, 64'h0, 3'd4, 32'h1_0000, 16'h1000, 32'h1_0000,
			32'h1_0000);
		send_item(32'h1_8000, 24'h200, 32'h2_0000, 16'h100);
		send_item(32'h5_0000, 24'h200, 32'h2_0000, 16'h100);
		drain();
		write_reg(aov_pkg::REG_OSC_WEIGHTS, 64'h0001_0001_0001_0001);
		write_reg(aov_pkg::REG_OSC_COUNT, 64'd0);
		send_item(32'h1_8000, 24'h200, 32'h2_0000, 16'h100);
		drain();

		// Every register at its top value.
		load_voice(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_reg(aov_pkg::REG_OSC_KINDS, 64'({aov_pkg::KIND_SQUARE, aov_pkg::KIND_SQUARE,
			aov_pkg::KIND_SQUARE, aov_pkg::KIND_SQUARE}));
		send_item(32'hFFFF_FFFF, 24'h0, 32'hFFFF_FFFF, 16'h0);
		send_item(32'h8000_0000, 24'h0, 32'h0, 16'h8000);
		drain();

		// Random voices; one phase holds the receiver off so the block backs up.
		for (int ph = 0; ph < 6; ph++) begin
			random_voice();
			if (ph == 2) begin
				hold_req = 1'b1;
				random_items(20);
			end
			random_items(70);
			drain();
		end
		quiet = 1'b1;
		random_voice();
		random_items(60);
		drain();

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
